@@ hw/rtl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked property checks used by variable_record_ring_fifo; reset masks each check.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a property holds at every rising edge out of reset.
`define VRRF_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Check that a condition never holds at a rising edge out of reset.
`define VRRF_ASSERT_NEVER(lbl, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error(msg);

`endif

@@ hw/rtl/vrrf_pkg.sv @@
// ----------------------------------------------------------------------------
// vrrf_pkg
// Sizes, codes and types of the variable record ring FIFO.
// ----------------------------------------------------------------------------
package vrrf_pkg;

    localparam int RECORD_SLOTS = 16;
    localparam int BYTE_DEPTH   = 64;
    localparam int RECORD_MAX   = 64;

    localparam int ACT_W  = 2;
    localparam int STAT_W = 2;
    localparam int TYPE_W = 16;
    localparam int LEN_W  = 7;
    localparam int BYTE_W = 8;

    localparam int SLOT_W  = $clog2(RECORD_SLOTS);
    localparam int USED_W  = $clog2(RECORD_SLOTS + 1);
    localparam int BYTE_AW = $clog2(BYTE_DEPTH);
    localparam int FREE_W  = $clog2(BYTE_DEPTH + 1);
    localparam int CMP_W   = (FREE_W > LEN_W) ? FREE_W : LEN_W;

    localparam int IN_BITS     = ACT_W + TYPE_W + LEN_W + BYTE_W;
    localparam int IN_TDATA_W  = ((IN_BITS + 7) / 8) * 8;
    localparam int OUT_BITS    = STAT_W + TYPE_W + LEN_W + BYTE_W;
    localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;

    typedef enum logic [ACT_W-1:0] {
        ACT_BEGIN = 2'd0,
        ACT_DATA  = 2'd1,
        ACT_POP   = 2'd2
    } action_t;

    typedef enum logic [STAT_W-1:0] {
        STAT_OK      = 2'd0,
        STAT_NO_ROOM = 2'd1,
        STAT_EMPTY   = 2'd2,
        STAT_SEQ     = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DESC,
        ST_BYTES
    } state_t;

    typedef struct packed {
        logic [TYPE_W-1:0] rtype;
        logic [LEN_W-1:0]  rlen;
    } desc_t;

    typedef struct packed {
        status_t           status;
        logic [TYPE_W-1:0] rtype;
        logic [LEN_W-1:0]  rlen;
        logic [BYTE_W-1:0] dbyte;
        logic              has_data;
        logic              last;
    } out_item_t;

    function automatic logic [SLOT_W-1:0] next_slot(input logic [SLOT_W-1:0] idx);
        return (idx == SLOT_W'(RECORD_SLOTS - 1)) ? '0 : idx + SLOT_W'(1);
    endfunction

    function automatic logic [BYTE_AW-1:0] next_byte(input logic [BYTE_AW-1:0] idx);
        return (idx == BYTE_AW'(BYTE_DEPTH - 1)) ? '0 : idx + BYTE_AW'(1);
    endfunction

endpackage

@@ hw/rtl/variable_record_ring_fifo.sv @@
// ----------------------------------------------------------------------------
// variable_record_ring_fifo
// FIFO of variable-length records: descriptor ring plus wrapping byte ring.
// ----------------------------------------------------------------------------
//  channel | ports                      | carries
//  --------+----------------------------+-------------------------------------
//  s_*     | tvalid tready tdata        | action, record type, length, byte
//  m_*     | tvalid tready tdata tuser  | status, type, length, byte, has_data
//          | tlast                      | last result of the transaction
//
//  Each push transaction and an empty pop give their result through the output
//  register. After its accepting cycle a pop of an N-byte record holds input
//  off through a descriptor-read state and then a byte state until every byte
//  is out; a zero-length record gives its result from the descriptor state.
//  A stalled output holds its result, the current byte and the input.
//  Reset clears pointers, counts and the open push; memories need no clearing.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module variable_record_ring_fifo
    import vrrf_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    // action, record_type, record_length, data_byte
    input  logic [IN_TDATA_W-1:0]  s_tdata,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // status, record_type_res, record_length_res, data_byte_res
    output logic [OUT_TDATA_W-1:0] m_tdata,
    // has_data
    output logic                   m_tuser,
    output logic                   m_tlast
);

    state_t              state_reg, state_next;
    logic [SLOT_W-1:0]   slot_head_reg, slot_head_next;
    logic [SLOT_W-1:0]   slot_tail_reg, slot_tail_next;
    logic [USED_W-1:0]   slots_used_reg, slots_used_next;
    logic [BYTE_AW-1:0]  byte_head_reg, byte_head_next;
    logic [BYTE_AW-1:0]  byte_tail_reg, byte_tail_next;
    logic [FREE_W-1:0]   bytes_free_reg, bytes_free_next;
    logic [LEN_W-1:0]    push_remaining_reg, push_remaining_next;
    logic                push_open_reg, push_open_next;
    logic [LEN_W-1:0]    count_reg, count_next;
    out_item_t           out_reg, out_next;
    logic                out_valid_reg, out_valid_next;

    desc_t               desc_mem [RECORD_SLOTS];
    logic [BYTE_W-1:0]   byte_mem [BYTE_DEPTH];
    desc_t               desc_q_reg;
    logic [BYTE_W-1:0]   byte_q_reg;
    logic                desc_we;
    logic                byte_we;

    logic [ACT_W-1:0]    in_action;
    logic [TYPE_W-1:0]   in_type;
    logic [LEN_W-1:0]    in_len;
    logic [BYTE_W-1:0]   in_byte;
    logic                out_free;
    logic                in_fire;

    assign in_action = s_tdata[1:0];
    assign in_type   = s_tdata[17:2];
    assign in_len    = s_tdata[24:18];
    assign in_byte   = s_tdata[32:25];

    assign out_free = !out_valid_reg || m_tready;
    assign s_tready = (state_reg == ST_IDLE) && out_free;
    assign in_fire  = s_tvalid && s_tready;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(OUT_TDATA_W - OUT_BITS){1'b0}}, out_reg.dbyte, out_reg.rlen,
                       out_reg.rtype, out_reg.status};
    assign m_tuser  = out_reg.has_data;
    assign m_tlast  = out_reg.last;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire && (in_action == ACT_POP) && (slots_used_reg != '0))
                begin
                    state_next = ST_DESC;
                end
            end
            ST_DESC:
            begin
                if (desc_q_reg.rlen != '0)
                begin
                    state_next = ST_BYTES;
                end
                else if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_BYTES:
            begin
                if (out_free && (count_reg == LEN_W'(1)))
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        slot_head_next      = slot_head_reg;
        slot_tail_next      = slot_tail_reg;
        slots_used_next     = slots_used_reg;
        byte_head_next      = byte_head_reg;
        byte_tail_next      = byte_tail_reg;
        bytes_free_next     = bytes_free_reg;
        push_remaining_next = push_remaining_reg;
        push_open_next      = push_open_reg;
        count_next          = count_reg;
        out_next            = out_reg;
        out_valid_next      = out_valid_reg && !m_tready;
        desc_we             = 1'b0;
        byte_we             = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    out_valid_next = 1'b1;
                    out_next       = '{status: STAT_OK, rtype: '0, rlen: '0, dbyte: '0,
                                       has_data: 1'b0, last: 1'b1};
                    unique case (in_action)
                        ACT_BEGIN:
                        begin
                            if (push_open_reg)
                            begin
                                out_next.status = STAT_SEQ;
                            end
                            else if ((slots_used_reg == USED_W'(RECORD_SLOTS)) ||
                                     (CMP_W'(in_len) > CMP_W'(bytes_free_reg)) ||
                                     (in_len > LEN_W'(RECORD_MAX)))
                            begin
                                out_next.status = STAT_NO_ROOM;
                            end
                            else
                            begin
                                desc_we         = 1'b1;
                                bytes_free_next = bytes_free_reg - FREE_W'(in_len);
                                if (in_len == '0)
                                begin
                                    slot_tail_next  = next_slot(slot_tail_reg);
                                    slots_used_next = slots_used_reg + USED_W'(1);
                                end
                                else
                                begin
                                    push_open_next      = 1'b1;
                                    push_remaining_next = in_len;
                                end
                            end
                        end
                        ACT_DATA:
                        begin
                            if (!push_open_reg)
                            begin
                                out_next.status = STAT_SEQ;
                            end
                            else
                            begin
                                byte_we             = 1'b1;
                                byte_tail_next      = next_byte(byte_tail_reg);
                                push_remaining_next = push_remaining_reg - LEN_W'(1);
                                if (push_remaining_reg == LEN_W'(1))
                                begin
                                    push_open_next  = 1'b0;
                                    slot_tail_next  = next_slot(slot_tail_reg);
                                    slots_used_next = slots_used_reg + USED_W'(1);
                                end
                            end
                        end
                        ACT_POP:
                        begin
                            if (slots_used_reg == '0)
                            begin
                                out_next.status = STAT_EMPTY;
                            end
                            else
                            begin
                                out_valid_next = out_valid_reg && !m_tready;
                            end
                        end
                        default:
                        begin
                            out_next.status = STAT_SEQ;
                        end
                    endcase
                end
            end
            ST_DESC:
            begin
                if (desc_q_reg.rlen != '0)
                begin
                    count_next = desc_q_reg.rlen;
                end
                else if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_next        = '{status: STAT_OK, rtype: desc_q_reg.rtype, rlen: '0,
                                        dbyte: '0, has_data: 1'b0, last: 1'b1};
                    slot_head_next  = next_slot(slot_head_reg);
                    slots_used_next = slots_used_reg - USED_W'(1);
                end
            end
            ST_BYTES:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_next       = '{status: STAT_OK, rtype: desc_q_reg.rtype,
                                       rlen: desc_q_reg.rlen, dbyte: byte_q_reg,
                                       has_data: 1'b1, last: (count_reg == LEN_W'(1))};
                    byte_head_next = next_byte(byte_head_reg);
                    count_next     = count_reg - LEN_W'(1);
                    if (count_reg == LEN_W'(1))
                    begin
                        slot_head_next  = next_slot(slot_head_reg);
                        slots_used_next = slots_used_reg - USED_W'(1);
                        bytes_free_next = bytes_free_reg + FREE_W'(desc_q_reg.rlen);
                    end
                end
            end
            default:
            begin
                out_valid_next = out_valid_reg && !m_tready;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg          <= ST_IDLE;
            slot_head_reg      <= '0;
            slot_tail_reg      <= '0;
            slots_used_reg     <= '0;
            byte_head_reg      <= '0;
            byte_tail_reg      <= '0;
            bytes_free_reg     <= FREE_W'(BYTE_DEPTH);
            push_remaining_reg <= '0;
            push_open_reg      <= 1'b0;
            count_reg          <= '0;
            out_valid_reg      <= 1'b0;
        end
        else
        begin
            state_reg          <= state_next;
            slot_head_reg      <= slot_head_next;
            slot_tail_reg      <= slot_tail_next;
            slots_used_reg     <= slots_used_next;
            byte_head_reg      <= byte_head_next;
            byte_tail_reg      <= byte_tail_next;
            bytes_free_reg     <= bytes_free_next;
            push_remaining_reg <= push_remaining_next;
            push_open_reg      <= push_open_next;
            count_reg          <= count_next;
            out_valid_reg      <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    // Read ahead at the next head so the read data is current when a pop starts
    always_ff @(posedge clk)
    begin
        if (desc_we)
        begin
            desc_mem[slot_tail_reg] <= '{rtype: in_type, rlen: in_len};
        end
        desc_q_reg <= desc_mem[slot_head_next];
    end

    always_ff @(posedge clk)
    begin
        if (byte_we)
        begin
            byte_mem[byte_tail_reg] <= in_byte;
        end
        byte_q_reg <= byte_mem[byte_head_next];
    end

    `VRRF_ASSERT(a_used_bound, slots_used_reg <= USED_W'(RECORD_SLOTS), "slot count overflow")
    `VRRF_ASSERT(a_free_bound, bytes_free_reg <= FREE_W'(BYTE_DEPTH), "free byte overflow")
    `VRRF_ASSERT(a_open_due, push_open_reg |-> push_remaining_reg != '0, "no bytes due")
    `VRRF_ASSERT_NEVER(a_pop_empty, state_reg != ST_IDLE && slots_used_reg == '0, "empty pop")
    `VRRF_ASSERT(a_byte_count, state_reg == ST_BYTES |-> count_reg != '0, "zero byte count")

endmodule

@@ dv/variable_record_ring_fifo_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// variable_record_ring_fifo_test
// Streams push_begin, push_data, pop and undefined-action transactions into the record FIFO,
// keeps its own image of the descriptor ring and the byte ring, and compares
// every result transaction, field by field, with the next response that the
// image gives. Covers directed corner cases, random well-formed records with
// noise, three idle profiles and one long output stall.
// ----------------------------------------------------------------------------
module variable_record_ring_fifo_test;
    import vrrf_pkg::*;

    localparam logic [ACT_W-1:0] ACT_UNDEF = 2'd3;
    localparam int HOLD_CYCLES = 400;
    localparam int STALL_LIMIT = 5000;
    localparam int DRAIN_CYCLES = 8;

    logic                   clk;
    logic                   rst_n;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic                   m_tuser;
    logic                   m_tlast;

    variable_record_ring_fifo uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    logic [TYPE_W-1:0]  ring_types [RECORD_SLOTS];
    logic [LEN_W-1:0]   ring_lengths [RECORD_SLOTS];
    logic [BYTE_W-1:0]  ring_bytes [BYTE_DEPTH];
    logic [SLOT_W-1:0]  slot_rd;
    logic [SLOT_W-1:0]  slot_wr;
    int                 slot_count;
    logic [BYTE_AW-1:0] byte_rd;
    logic [BYTE_AW-1:0] byte_wr;
    int                 free_bytes;
    int                 bytes_due;
    bit                 push_active;

    out_item_t ring_responses [$];
    out_item_t oldest;
    int        mismatches;
    int        send_idle_pct;
    int        recv_idle_pct;
    int        hold_requests;
    int        hold_seen;
    int        hold_left;
    int        quiet_cycles;

    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    function automatic out_item_t status_only(status_t code);
        out_item_t r;
        r = '0;
        r.status = code;
        r.last = 1'b1;
        return r;
    endfunction

    task automatic apply_ring_action(input logic [ACT_W-1:0] act,
                                     input logic [TYPE_W-1:0] rtype,
                                     input logic [LEN_W-1:0] rlen,
                                     input logic [BYTE_W-1:0] dbyte);
        out_item_t r;
        int        len;
        if (act == ACT_BEGIN)
        begin
            if (push_active)
                ring_responses.push_back(status_only(STAT_SEQ));
            else if (slot_count >= RECORD_SLOTS || int'(rlen) > free_bytes
                     || int'(rlen) > RECORD_MAX)
                ring_responses.push_back(status_only(STAT_NO_ROOM));
            else
            begin
                ring_types[slot_wr] = rtype;
                ring_lengths[slot_wr] = rlen;
                free_bytes -= int'(rlen);
                if (rlen == 0)
                begin
                    slot_wr = next_slot(slot_wr);
                    slot_count++;
                end
                else
                begin
                    push_active = 1'b1;
                    bytes_due = int'(rlen);
                end
                ring_responses.push_back(status_only(STAT_OK));
            end
        end
        else if (act == ACT_DATA)
        begin
            if (!push_active)
                ring_responses.push_back(status_only(STAT_SEQ));
            else
            begin
                ring_bytes[byte_wr] = dbyte;
                byte_wr = next_byte(byte_wr);
                bytes_due--;
                if (bytes_due == 0)
                begin
                    push_active = 1'b0;
                    slot_wr = next_slot(slot_wr);
                    slot_count++;
                end
                ring_responses.push_back(status_only(STAT_OK));
            end
        end
        else if (act == ACT_POP)
        begin
            if (slot_count == 0)
                ring_responses.push_back(status_only(STAT_EMPTY));
            else
            begin
                len = int'(ring_lengths[slot_rd]);
                if (len == 0)
                begin
                    r = status_only(STAT_OK);
                    r.rtype = ring_types[slot_rd];
                    ring_responses.push_back(r);
                end
                for (int i = 0; i < len; i++)
                begin
                    r = '0;
                    r.status = STAT_OK;
                    r.rtype = ring_types[slot_rd];
                    r.rlen = ring_lengths[slot_rd];
                    r.dbyte = ring_bytes[byte_rd];
                    r.has_data = 1'b1;
                    r.last = (i == len - 1);
                    ring_responses.push_back(r);
                    byte_rd = next_byte(byte_rd);
                end
                free_bytes += len;
                slot_rd = next_slot(slot_rd);
                slot_count--;
            end
        end
        else
            ring_responses.push_back(status_only(STAT_SEQ));
    endtask

    task automatic send_item(input logic [ACT_W-1:0] act,
                             input logic [TYPE_W-1:0] rtype,
                             input logic [LEN_W-1:0] rlen,
                             input logic [BYTE_W-1:0] dbyte);
        logic [IN_TDATA_W-1:0] word;
        word = '0;
        word[0 +: ACT_W] = act;
        word[ACT_W +: TYPE_W] = rtype;
        word[ACT_W + TYPE_W +: LEN_W] = rlen;
        word[ACT_W + TYPE_W + LEN_W +: BYTE_W] = dbyte;
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= word;
        do
            @(posedge clk);
        while (!s_tready);
        apply_ring_action(act, rtype, rlen, dbyte);
        @(negedge clk);
    endtask

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch %s: got 0x%0h, want 0x%0h at %0t", what, got, want, $realtime);
        mismatches++;
    endtask

    always @(negedge clk)
    begin
        if (hold_seen != hold_requests)
        begin
            hold_seen = hold_requests;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            m_tready <= 1'b0;
        end
        else
            m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (ring_responses.size() == 0)
                report_mismatch("unexpected transaction", int'(m_tdata), 0);
            else
            begin
                oldest = ring_responses.pop_front();
                if (m_tdata[0 +: STAT_W] != oldest.status)
                    report_mismatch("status", int'(m_tdata[0 +: STAT_W]),
                                    int'(oldest.status));
                if (m_tdata[STAT_W +: TYPE_W] != oldest.rtype)
                    report_mismatch("record_type", int'(m_tdata[STAT_W +: TYPE_W]),
                                    int'(oldest.rtype));
                if (m_tdata[STAT_W + TYPE_W +: LEN_W] != oldest.rlen)
                    report_mismatch("record_length",
                                    int'(m_tdata[STAT_W + TYPE_W +: LEN_W]),
                                    int'(oldest.rlen));
                if (m_tdata[STAT_W + TYPE_W + LEN_W +: BYTE_W] != oldest.dbyte)
                    report_mismatch("data_byte",
                                    int'(m_tdata[STAT_W + TYPE_W + LEN_W +: BYTE_W]),
                                    int'(oldest.dbyte));
                if (m_tuser != oldest.has_data)
                    report_mismatch("has_data", int'(m_tuser), int'(oldest.has_data));
                if (m_tlast != oldest.last)
                    report_mismatch("last", int'(m_tlast), int'(oldest.last));
            end
        end
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    task automatic test_directed_cases();
        send_item(ACT_POP, 16'h0000, 7'd0, 8'h00);
        send_item(ACT_DATA, 16'h0000, 7'd0, 8'hA5);
        send_item(ACT_UNDEF, 16'hFFFF, 7'h7F, 8'hFF);
        send_item(ACT_BEGIN, 16'hFFFF, 7'd0, 8'h00);
        send_item(ACT_BEGIN, 16'h1234, 7'd65, 8'h00);
        send_item(ACT_BEGIN, 16'h0000, 7'd127, 8'h00);
        send_item(ACT_BEGIN, 16'h0000, 7'd2, 8'h00);
        send_item(ACT_BEGIN, 16'hABCD, 7'd1, 8'h00);
        send_item(ACT_POP, 16'h0000, 7'd0, 8'h00);
        send_item(ACT_DATA, 16'hFFFF, 7'h7F, 8'h00);
        send_item(ACT_DATA, 16'h0000, 7'd0, 8'hFF);
        send_item(ACT_POP, 16'hFFFF, 7'h7F, 8'hFF);
        send_item(ACT_POP, 16'h0000, 7'd0, 8'h00);
        send_item(ACT_BEGIN, 16'h8001, 7'd1, 8'h00);
        send_item(ACT_DATA, 16'h0000, 7'd0, 8'h5A);
        send_item(ACT_DATA, 16'h0000, 7'd0, 8'hC3);
        send_item(ACT_POP, 16'h0000, 7'd0, 8'h00);
    endtask

    task automatic test_random_traffic(input int count, input int sender_pct,
                                       input int receiver_pct);
        logic [ACT_W-1:0]  act;
        logic [TYPE_W-1:0] rtype;
        logic [LEN_W-1:0]  rlen;
        logic [BYTE_W-1:0] dbyte;
        int                mode;
        int                pop_pct;
        int                pick;
        send_idle_pct = sender_pct;
        recv_idle_pct = receiver_pct;
        for (int n = 0; n < count; n++)
        begin
            mode = (n / 30) % 3;
            pop_pct = (mode == 0) ? 55 : (mode == 1) ? 12 : 15;
            rtype = TYPE_W'($urandom_range(0, 16'hFFFF));
            rlen = LEN_W'($urandom_range(0, 127));
            dbyte = BYTE_W'($urandom_range(0, 255));
            pick = $urandom_range(0, 99);
            if (push_active)
                act = (pick < 80) ? ACT_DATA : (pick < 88) ? ACT_POP :
                      (pick < 95) ? ACT_BEGIN : ACT_UNDEF;
            else if (pick < 10)
            begin
                act = (pick < 4) ? ACT_DATA : (pick < 7) ? ACT_UNDEF : ACT_BEGIN;
                if (act == ACT_BEGIN)
                    rlen = LEN_W'($urandom_range(65, 127));
            end
            else if (pick < 10 + pop_pct)
                act = ACT_POP;
            else
            begin
                act = ACT_BEGIN;
                pick = $urandom_range(0, 99);
                if (mode == 1)
                    rlen = LEN_W'($urandom_range(0, 2));
                else if (pick < 50)
                    rlen = LEN_W'($urandom_range(0, 6));
                else if (pick < 75)
                    rlen = LEN_W'($urandom_range(7, 24));
                else if (pick < 92)
                    rlen = LEN_W'($urandom_range(25, 63));
                else
                    rlen = LEN_W'(RECORD_MAX);
            end
            send_item(act, rtype, rlen, dbyte);
        end
    endtask

    task automatic test_output_backpressure();
        hold_requests++;
        test_random_traffic(48, 0, 0);
    endtask

    initial
    begin
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        m_tready = 1'b0;
        slot_rd = '0;
        slot_wr = '0;
        slot_count = 0;
        byte_rd = '0;
        byte_wr = '0;
        free_bytes = BYTE_DEPTH;
        bytes_due = 0;
        push_active = 1'b0;
        mismatches = 0;
        send_idle_pct = 25;
        recv_idle_pct = 46;
        hold_requests = 0;
        hold_seen = 0;
        hold_left = 0;
        quiet_cycles = 0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_directed_cases();
        test_random_traffic(160, 25, 46);
        test_random_traffic(160, 46, 25);
        test_random_traffic(160, 0, 0);
        test_output_backpressure();

        s_tvalid <= 1'b0;
        while (ring_responses.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

@@ variable_record_ring_fifo.f @@
+incdir+hw/rtl
hw/rtl/vrrf_pkg.sv
hw/rtl/variable_record_ring_fifo.sv
dv/variable_record_ring_fifo_test.sv
